FILE: rtl/core/obb_pkg.sv
// Shared widths and payload types for the oriented box overlap test pipeline.
`default_nettype none

package obb_pkg;

    // Input field widths.
    localparam int CW   = 24;            // centre coordinate, Q15.8 signed
    localparam int HW   = 16;            // half size, Q8.8 unsigned
    localparam int AW   = 16;            // axis component, Q1.14 signed

    // Internal widths.
    localparam int DIFW = CW + 1;        // centre difference
    localparam int APW  = 2 * AW;        // axis by axis product, signed
    localparam int ASW  = APW + 1;       // axis by axis sum, signed
    localparam int AMW  = APW;           // magnitude of an axis by axis sum
    localparam int DPW  = DIFW + AW;     // centre difference by axis product
    localparam int DSW  = DPW + 1;       // projected centre distance, signed
    localparam int DMW  = DPW;           // magnitude of projected distance
    localparam int RPW  = HW + AMW;      // half size by axis magnitude
    localparam int RSW  = RPW + 2;       // sum of three radius terms
    localparam int SHIFT = 14;           // axis scale, aligns distance to radius
    localparam int CMPW = DMW + SHIFT + 1;

    // One pair of boxes as it enters the pipeline.
    typedef struct packed {
        logic signed [CW-1:0] a_cx;
        logic signed [CW-1:0] a_cy;
        logic        [HW-1:0] a_hw;
        logic        [HW-1:0] a_hh;
        logic signed [AW-1:0] a_ux;
        logic signed [AW-1:0] a_uy;
        logic signed [CW-1:0] b_cx;
        logic signed [CW-1:0] b_cy;
        logic        [HW-1:0] b_hw;
        logic        [HW-1:0] b_hh;
        logic signed [AW-1:0] b_ux;
        logic signed [AW-1:0] b_uy;
    } t_boxes;

    // Projected distances and axis magnitudes after the projection stages.
    typedef struct packed {
        logic [DMW-1:0] d1;
        logic [DMW-1:0] d2;
        logic [DMW-1:0] d3;
        logic [DMW-1:0] d4;
        logic [AMW-1:0] paa;
        logic [AMW-1:0] pbb;
        logic [AMW-1:0] mc;
        logic [AMW-1:0] ms;
        logic [HW-1:0]  a_hw;
        logic [HW-1:0]  a_hh;
        logic [HW-1:0]  b_hw;
        logic [HW-1:0]  b_hh;
    } t_proj;

    // Summed radii on each of the four axes, with the matching distances.
    typedef struct packed {
        logic [RSW-1:0] r1;
        logic [RSW-1:0] r2;
        logic [RSW-1:0] r3;
        logic [RSW-1:0] r4;
        logic [DMW-1:0] d1;
        logic [DMW-1:0] d2;
        logic [DMW-1:0] d3;
        logic [DMW-1:0] d4;
    } t_rad;

endpackage

`default_nettype wire

FILE: rtl/core/obb_proj.sv
// Projection stages: centre difference, axis products and projected distances.
`default_nettype none

module obb_proj
    import obb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_boxes i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_proj       o_data
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // Stage one registers.
    logic signed [DIFW-1:0] r1_dx, r1_dy;
    logic signed [AW-1:0]   r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [APW-1:0]  r1_pxx, r1_pyy, r1_pyx, r1_pxy;
    logic signed [APW-1:0]  r1_aa0, r1_aa1, r1_bb0, r1_bb1;
    logic [HW-1:0]          r1_ahw, r1_ahh, r1_bhw, r1_bhh;

    // Stage two registers.
    logic signed [ASW-1:0]  r2_c, r2_s;
    logic [AMW-1:0]         r2_paa, r2_pbb;
    logic signed [DPW-1:0]  r2_xa, r2_ya, r2_xay, r2_yax;
    logic signed [DPW-1:0]  r2_xb, r2_yb, r2_xby, r2_ybx;
    logic [HW-1:0]          r2_ahw, r2_ahh, r2_bhw, r2_bhh;

    // Stage three logic and registers.
    logic signed [DSW-1:0]  n_d1, n_d2, n_d3, n_d4;
    t_proj                  n_out;
    t_proj                  r3_out;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r3_out;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage one: centre difference and axis by axis products.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_dx  <= DIFW'(i_data.b_cx) - DIFW'(i_data.a_cx);
            r1_dy  <= DIFW'(i_data.b_cy) - DIFW'(i_data.a_cy);
            r1_ax  <= i_data.a_ux;
            r1_ay  <= i_data.a_uy;
            r1_bx  <= i_data.b_ux;
            r1_by  <= i_data.b_uy;
            r1_pxx <= APW'(i_data.a_ux) * APW'(i_data.b_ux);
            r1_pyy <= APW'(i_data.a_uy) * APW'(i_data.b_uy);
            r1_pyx <= APW'(i_data.a_uy) * APW'(i_data.b_ux);
            r1_pxy <= APW'(i_data.a_ux) * APW'(i_data.b_uy);
            r1_aa0 <= APW'(i_data.a_ux) * APW'(i_data.a_ux);
            r1_aa1 <= APW'(i_data.a_uy) * APW'(i_data.a_uy);
            r1_bb0 <= APW'(i_data.b_ux) * APW'(i_data.b_ux);
            r1_bb1 <= APW'(i_data.b_uy) * APW'(i_data.b_uy);
            r1_ahw <= i_data.a_hw;
            r1_ahh <= i_data.a_hh;
            r1_bhw <= i_data.b_hw;
            r1_bhh <= i_data.b_hh;
        end
    end

    // Stage two: cosine and sine between the boxes, squared lengths, and the
    // centre difference multiplied by each axis component.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_c   <= ASW'(r1_pxx) + ASW'(r1_pyy);
            r2_s   <= ASW'(r1_pyx) - ASW'(r1_pxy);
            r2_paa <= AMW'($unsigned(r1_aa0)) + AMW'($unsigned(r1_aa1));
            r2_pbb <= AMW'($unsigned(r1_bb0)) + AMW'($unsigned(r1_bb1));
            r2_xa  <= DPW'(r1_dx) * DPW'(r1_ax);
            r2_ya  <= DPW'(r1_dy) * DPW'(r1_ay);
            r2_xay <= DPW'(r1_dx) * DPW'(r1_ay);
            r2_yax <= DPW'(r1_dy) * DPW'(r1_ax);
            r2_xb  <= DPW'(r1_dx) * DPW'(r1_bx);
            r2_yb  <= DPW'(r1_dy) * DPW'(r1_by);
            r2_xby <= DPW'(r1_dx) * DPW'(r1_by);
            r2_ybx <= DPW'(r1_dy) * DPW'(r1_bx);
            r2_ahw <= r1_ahw;
            r2_ahh <= r1_ahh;
            r2_bhw <= r1_bhw;
            r2_bhh <= r1_bhh;
        end
    end

    // Stage three: projected distances on the four axes and all magnitudes.
    always_comb begin
        n_d1 = DSW'(r2_xa) + DSW'(r2_ya);
        n_d2 = DSW'(r2_yax) - DSW'(r2_xay);
        n_d3 = DSW'(r2_xb) + DSW'(r2_yb);
        n_d4 = DSW'(r2_ybx) - DSW'(r2_xby);
        n_out.d1   = DMW'(n_d1[DSW-1] ? -n_d1 : n_d1);
        n_out.d2   = DMW'(n_d2[DSW-1] ? -n_d2 : n_d2);
        n_out.d3   = DMW'(n_d3[DSW-1] ? -n_d3 : n_d3);
        n_out.d4   = DMW'(n_d4[DSW-1] ? -n_d4 : n_d4);
        n_out.mc   = AMW'(r2_c[ASW-1] ? -r2_c : r2_c);
        n_out.ms   = AMW'(r2_s[ASW-1] ? -r2_s : r2_s);
        n_out.paa  = r2_paa;
        n_out.pbb  = r2_pbb;
        n_out.a_hw = r2_ahw;
        n_out.a_hh = r2_ahh;
        n_out.b_hw = r2_bhw;
        n_out.b_hh = r2_bhh;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/obb_radius.sv
// Radius stages: half sizes times axis magnitudes, summed per axis.
`default_nettype none

module obb_radius
    import obb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_proj i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_rad       o_data
);

    logic r_v4, r_v5;
    logic en4, en5;

    // Stage four registers: one product per radius term.
    logic [RPW-1:0] r4_aw_paa, r4_ah_paa, r4_bw_pbb, r4_bh_pbb;
    logic [RPW-1:0] r4_aw_mc, r4_aw_ms, r4_ah_mc, r4_ah_ms;
    logic [RPW-1:0] r4_bw_mc, r4_bw_ms, r4_bh_mc, r4_bh_ms;
    logic [DMW-1:0] r4_d1, r4_d2, r4_d3, r4_d4;

    t_rad r5_out;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v5;
    assign o_data  = r5_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage four: half sizes scaled by the axis magnitudes.
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_aw_paa <= RPW'(i_data.a_hw) * RPW'(i_data.paa);
            r4_ah_paa <= RPW'(i_data.a_hh) * RPW'(i_data.paa);
            r4_bw_pbb <= RPW'(i_data.b_hw) * RPW'(i_data.pbb);
            r4_bh_pbb <= RPW'(i_data.b_hh) * RPW'(i_data.pbb);
            r4_aw_mc  <= RPW'(i_data.a_hw) * RPW'(i_data.mc);
            r4_aw_ms  <= RPW'(i_data.a_hw) * RPW'(i_data.ms);
            r4_ah_mc  <= RPW'(i_data.a_hh) * RPW'(i_data.mc);
            r4_ah_ms  <= RPW'(i_data.a_hh) * RPW'(i_data.ms);
            r4_bw_mc  <= RPW'(i_data.b_hw) * RPW'(i_data.mc);
            r4_bw_ms  <= RPW'(i_data.b_hw) * RPW'(i_data.ms);
            r4_bh_mc  <= RPW'(i_data.b_hh) * RPW'(i_data.mc);
            r4_bh_ms  <= RPW'(i_data.b_hh) * RPW'(i_data.ms);
            r4_d1     <= i_data.d1;
            r4_d2     <= i_data.d2;
            r4_d3     <= i_data.d3;
            r4_d4     <= i_data.d4;
        end
    end

    // Stage five: summed radii. A box's own cross term is always zero, so
    // each axis has three terms.
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_out.r1 <= RSW'(r4_aw_paa) + RSW'(r4_bw_mc) + RSW'(r4_bh_ms);
            r5_out.r2 <= RSW'(r4_ah_paa) + RSW'(r4_bw_ms) + RSW'(r4_bh_mc);
            r5_out.r3 <= RSW'(r4_aw_mc) + RSW'(r4_ah_ms) + RSW'(r4_bw_pbb);
            r5_out.r4 <= RSW'(r4_aw_ms) + RSW'(r4_ah_mc) + RSW'(r4_bh_pbb);
            r5_out.d1 <= r4_d1;
            r5_out.d2 <= r4_d2;
            r5_out.d3 <= r4_d3;
            r5_out.d4 <= r4_d4;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/obb_cmp.sv
// Final stage: per-axis distance against radius compare and the output register.
`default_nettype none

module obb_cmp
    import obb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_rad i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic      o_overlap
);

    logic r_v6;
    logic r_overlap;
    logic en6;
    logic n_overlap;

    assign en6       = !r_v6 || i_ready;
    assign o_ready   = en6;
    assign o_valid   = r_v6;
    assign o_overlap = r_overlap;

    // Touching counts as overlap, so the compare is less or equal.
    always_comb begin
        n_overlap = ((CMPW'(i_data.d1) << SHIFT) <= CMPW'(i_data.r1))
                 && ((CMPW'(i_data.d2) << SHIFT) <= CMPW'(i_data.r2))
                 && ((CMPW'(i_data.d3) << SHIFT) <= CMPW'(i_data.r3))
                 && ((CMPW'(i_data.d4) << SHIFT) <= CMPW'(i_data.r4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en6) begin
            r_v6 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_overlap <= n_overlap;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/oriented_box_overlap_test.sv
// Top level of the 2D oriented box overlap test.
// Six register stages lie between an accepted request and its result on the master side.
// Throughput: one box pair per cycle, since each of the six register stages takes
// a new request every cycle; a stall holds every stage without loss.
// Reset: synchronous, active low; it clears the valid bit of every stage.
`default_nettype none

module oriented_box_overlap_test
    import obb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // From bit 0 up: a_center_x, a_center_y, a_half_width, a_half_height,
    // a_axis_cos, a_axis_sin, b_center_x, b_center_y, b_half_width,
    // b_half_height, b_axis_cos, b_axis_sin.
    input  wire logic [223:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // From bit 0 up: boxes_overlap, then seven zero bits.
    output logic [7:0]        o_m_tdata
);

    t_boxes in_boxes;
    t_proj  proj_data;
    t_rad   rad_data;
    logic   proj_valid, proj_ready;
    logic   rad_valid, rad_ready;
    logic   overlap;

    // Unpack the request fields.
    always_comb begin
        in_boxes.a_cx = i_s_tdata[23:0];
        in_boxes.a_cy = i_s_tdata[47:24];
        in_boxes.a_hw = i_s_tdata[63:48];
        in_boxes.a_hh = i_s_tdata[79:64];
        in_boxes.a_ux = i_s_tdata[95:80];
        in_boxes.a_uy = i_s_tdata[111:96];
        in_boxes.b_cx = i_s_tdata[135:112];
        in_boxes.b_cy = i_s_tdata[159:136];
        in_boxes.b_hw = i_s_tdata[175:160];
        in_boxes.b_hh = i_s_tdata[191:176];
        in_boxes.b_ux = i_s_tdata[207:192];
        in_boxes.b_uy = i_s_tdata[223:208];
    end

    obb_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (in_boxes),
        .o_valid (proj_valid),
        .i_ready (proj_ready),
        .o_data  (proj_data)
    );

    obb_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (proj_valid),
        .o_ready (proj_ready),
        .i_data  (proj_data),
        .o_valid (rad_valid),
        .i_ready (rad_ready),
        .o_data  (rad_data)
    );

    obb_cmp u_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (rad_valid),
        .o_ready   (rad_ready),
        .i_data    (rad_data),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_overlap (overlap)
    );

    assign o_m_tdata = {7'b0, overlap};

endmodule

`default_nettype wire
